### design/clr_pkg.sv
// clr_pkg: shared constants, register indexes and types of the clipped line rasterizer.
// Used by clr_step_core, clr_clip_addr and clipped_line_rasterizer_core.
`timescale 1ns / 1ps

package clr_pkg;

    // Coordinate width default (signed pixel coordinates)
    localparam int COORD_BITS_DEF = 13;

    // Fixed field widths
    localparam int SCREEN_BITS    = 12;
    localparam int ADDR_BITS      = 24;
    localparam int COLOR_BITS     = 32;
    localparam int CFG_INDEX_BITS = 1;

    // Screen size after reset
    localparam logic [SCREEN_BITS-1:0] FB_WIDTH_RESET  = 12'd320;
    localparam logic [SCREEN_BITS-1:0] FB_HEIGHT_RESET = 12'd200;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FB_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FB_HEIGHT = 1'd1;

    // Item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // Per-pixel status that travels with a result
    typedef struct packed {
        logic last;   // endpoint of the line
        logic idle;   // step arrived with no line active
    } pix_flags_t;

endpackage

### design/clr_step_core.sv
// clr_step_core: Bresenham line state and the per-transaction update (start or step).
// Depends on clr_pkg.
`timescale 1ns / 1ps

module clr_step_core
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         item_accept,
    input  logic                         kind,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] finish_x,
    input  logic signed [COORD_BITS-1:0] finish_y,
    input  logic [COLOR_BITS-1:0]        line_color,
    output logic signed [COORD_BITS-1:0] cur_x,
    output logic signed [COORD_BITS-1:0] cur_y,
    output logic [COLOR_BITS-1:0]        cur_color,
    output pix_flags_t                   cur_flags
);

    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;

    // Line state; current position doubles as the payload of the first stage
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg, tgt_x_reg, tgt_y_reg;
    logic [DELTA_BITS-1:0]        dx_reg, dy_reg;
    logic                         neg_x_reg, neg_y_reg;
    logic signed [ERR_BITS-1:0]   err_reg;
    logic [COLOR_BITS-1:0]        color_reg;
    logic                         active_reg;
    pix_flags_t                   flags_reg;

    // Start path
    logic signed [COORD_BITS:0]   diff_x, diff_y;
    logic [DELTA_BITS-1:0]        dx_start, dy_start;
    logic signed [ERR_BITS-1:0]   err_start;

    // Step path
    logic signed [ERR_BITS-1:0]   neg_dx, pos_dy, pos_dx;
    logic                         move_x, move_y;
    logic signed [ERR_BITS-1:0]   err_step;
    logic signed [COORD_BITS-1:0] x_step, y_step;

    // Selected next state
    logic signed [COORD_BITS-1:0] x_next, y_next, tx_next, ty_next;
    logic                         done;

    // Deltas, directions and initial error of a new line
    always_comb begin
        diff_x   = $signed({finish_x[COORD_BITS-1], finish_x})
                 - $signed({start_x[COORD_BITS-1], start_x});
        diff_y   = $signed({finish_y[COORD_BITS-1], finish_y})
                 - $signed({start_y[COORD_BITS-1], start_y});
        dx_start = diff_x[COORD_BITS] ? $unsigned(-diff_x) : $unsigned(diff_x);
        dy_start = diff_y[COORD_BITS] ? $unsigned(-diff_y) : $unsigned(diff_y);
        // half of dx, or half of -dy, truncated toward zero
        if (dx_start > dy_start) begin
            err_start = $signed(ERR_BITS'(dx_start >> 1));
        end else begin
            err_start = -$signed(ERR_BITS'(dy_start >> 1));
        end
    end

    // One Bresenham step
    always_comb begin
        pos_dx   = $signed(ERR_BITS'(dx_reg));
        pos_dy   = $signed(ERR_BITS'(dy_reg));
        neg_dx   = -pos_dx;
        move_x   = err_reg > neg_dx;
        move_y   = err_reg < pos_dy;
        err_step = err_reg - (move_x ? pos_dy : '0) + (move_y ? pos_dx : '0);
        // +1 or -1 built from the direction bit
        x_step   = move_x ? cur_x_reg + $signed({{(COORD_BITS-1){neg_x_reg}}, 1'b1})
                          : cur_x_reg;
        y_step   = move_y ? cur_y_reg + $signed({{(COORD_BITS-1){neg_y_reg}}, 1'b1})
                          : cur_y_reg;
    end

    // Endpoint detection on the new position
    always_comb begin
        if (kind == KIND_START) begin
            x_next  = start_x;
            y_next  = start_y;
            tx_next = finish_x;
            ty_next = finish_y;
        end else begin
            x_next  = x_step;
            y_next  = y_step;
            tx_next = tgt_x_reg;
            ty_next = tgt_y_reg;
        end
        done = (x_next == tx_next) && (y_next == ty_next);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            flags_reg  <= '0;
        end else if (item_accept) begin
            if (kind == KIND_START || active_reg) begin
                active_reg <= !done;
                flags_reg  <= '{last: done, idle: 1'b0};
            end else begin
                flags_reg  <= '{last: 1'b0, idle: 1'b1};
            end
        end
    end

    // Line datapath
    always_ff @(posedge aclk) begin
        if (item_accept) begin
            if (kind == KIND_START) begin
                cur_x_reg <= start_x;
                cur_y_reg <= start_y;
                tgt_x_reg <= finish_x;
                tgt_y_reg <= finish_y;
                color_reg <= line_color;
                dx_reg    <= dx_start;
                dy_reg    <= dy_start;
                neg_x_reg <= !(start_x < finish_x);
                neg_y_reg <= !(start_y < finish_y);
                err_reg   <= err_start;
            end else if (active_reg) begin
                cur_x_reg <= x_step;
                cur_y_reg <= y_step;
                err_reg   <= err_step;
            end
        end
    end

    assign cur_x     = cur_x_reg;
    assign cur_y     = cur_y_reg;
    assign cur_color = color_reg;
    assign cur_flags = flags_reg;

endmodule

### design/clr_clip_addr.sv
// clr_clip_addr: screen clipping and linear address y*width+x of one pixel.
// Depends on clr_pkg.
`timescale 1ns / 1ps

module clr_clip_addr
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] pix_x,
    input  logic signed [COORD_BITS-1:0] pix_y,
    input  logic [SCREEN_BITS-1:0]       width_lim,
    input  logic [SCREEN_BITS-1:0]       height_lim,
    output logic                         on_screen,
    output logic [ADDR_BITS-1:0]         address
);

    localparam int MAG_BITS = COORD_BITS - 1;
    localparam int CMP_BITS = (MAG_BITS > SCREEN_BITS) ? MAG_BITS : SCREEN_BITS;
    localparam int PROD_BITS = MAG_BITS + SCREEN_BITS;
    localparam int SUM_BITS = (PROD_BITS + 1 > ADDR_BITS) ? PROD_BITS + 1 : ADDR_BITS;

    logic [MAG_BITS-1:0]  x_mag, y_mag;
    logic [PROD_BITS-1:0] row_base;
    logic [SUM_BITS-1:0]  lin_addr;

    // Clip against the screen rectangle
    always_comb begin
        x_mag     = pix_x[MAG_BITS-1:0];
        y_mag     = pix_y[MAG_BITS-1:0];
        on_screen = !pix_x[COORD_BITS-1] && !pix_y[COORD_BITS-1]
                 && (CMP_BITS'(x_mag) < CMP_BITS'(width_lim))
                 && (CMP_BITS'(y_mag) < CMP_BITS'(height_lim));
    end

    // Row base plus column, kept to the address width
    always_comb begin
        row_base = PROD_BITS'(y_mag) * PROD_BITS'(width_lim);
        lin_addr = SUM_BITS'(row_base) + SUM_BITS'(x_mag);
        address  = on_screen ? lin_addr[ADDR_BITS-1:0] : '0;
    end

endmodule

### design/clipped_line_rasterizer_core.sv
// Clipped line rasterizer: an accepted transaction is registered in the line state of
// clr_step_core, then in the result register that offers it on the m_ side; throughput
// one transaction per cycle while m_tready does not stall the result register.
// Reset (aresetn low, synchronous) drops any active line, empties both stages and sets
// the screen to 320 x 200.
// Depends on clr_pkg, clr_step_core and clr_clip_addr.
`timescale 1ns / 1ps

module clipped_line_rasterizer_core
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // s_tdata from bit 0: start_x, start_y, finish_x, finish_y, line_color, zero fill
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                      s_tuser,   // kind
    // m_tdata from bit 0: write_enable, pixel_x, pixel_y, pixel_address, pixel_color,
    // zero fill
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [((1+2*COORD_BITS+ADDR_BITS+COLOR_BITS+7)/8)*8-1:0] m_tdata,
    output logic                      m_tuser,   // idle
    output logic                      m_tlast,
    // register writes
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SCREEN_BITS-1:0]    cfg_wr_data
);

    localparam int C = COORD_BITS;
    localparam int IN_DATA_BITS  = ((4*C+COLOR_BITS+7)/8)*8;
    localparam int OUT_FIELD_BITS = 1 + 2*C + ADDR_BITS + COLOR_BITS;
    localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS+7)/8)*8;

    logic [SCREEN_BITS-1:0] fb_width_reg, fb_height_reg;

    logic                  s1_valid_reg, out_valid_reg;
    logic                  out_advance, item_accept;

    logic signed [C-1:0]   cur_x, cur_y;
    logic [COLOR_BITS-1:0] cur_color;
    pix_flags_t            cur_flags;
    logic                  on_screen;
    logic [ADDR_BITS-1:0]  address;

    logic                  out_we_reg;
    logic signed [C-1:0]   out_x_reg, out_y_reg;
    logic [ADDR_BITS-1:0]  out_addr_reg;
    logic [COLOR_BITS-1:0] out_color_reg;
    pix_flags_t            out_flags_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_width_reg  <= FB_WIDTH_RESET;
            fb_height_reg <= FB_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FB_WIDTH:  fb_width_reg  <= cfg_wr_data;
                REG_FB_HEIGHT: fb_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Pipeline flow control: the output register moves when empty or taken
    assign out_advance = !out_valid_reg || m_tready;
    assign s_tready    = !s1_valid_reg || out_advance;
    assign item_accept = s_tvalid && s_tready;

    // Line state and stepping (first stage)
    clr_step_core #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (item_accept),
        .kind        (s_tuser),
        .start_x     ($signed(s_tdata[C-1:0])),
        .start_y     ($signed(s_tdata[2*C-1:C])),
        .finish_x    ($signed(s_tdata[3*C-1:2*C])),
        .finish_y    ($signed(s_tdata[4*C-1:3*C])),
        .line_color  (s_tdata[4*C+COLOR_BITS-1:4*C]),
        .cur_x       (cur_x),
        .cur_y       (cur_y),
        .cur_color   (cur_color),
        .cur_flags   (cur_flags)
    );

    // Clipping and address (second stage)
    clr_clip_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_clip (
        .pix_x      (cur_x),
        .pix_y      (cur_y),
        .width_lim  (fb_width_reg),
        .height_lim (fb_height_reg),
        .on_screen  (on_screen),
        .address    (address)
    );

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (item_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (out_advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (out_advance) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Result register; an idle result carries zeros
    always_ff @(posedge aclk) begin
        if (out_advance && s1_valid_reg) begin
            out_flags_reg <= cur_flags;
            if (cur_flags.idle) begin
                out_we_reg    <= 1'b0;
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_addr_reg  <= '0;
                out_color_reg <= '0;
            end else begin
                out_we_reg    <= on_screen;
                out_x_reg     <= cur_x;
                out_y_reg     <= cur_y;
                out_addr_reg  <= address;
                out_color_reg <= cur_color;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_BITS'({out_color_reg, out_addr_reg, out_y_reg, out_x_reg,
                                      out_we_reg});
    assign m_tuser  = out_flags_reg.idle;
    assign m_tlast  = out_flags_reg.last;

    // Zero fill bits of s_tdata are ignored
    logic unused_in_fill;
    assign unused_in_fill = ^s_tdata[IN_DATA_BITS-1:4*C+COLOR_BITS];

endmodule
